@@ src/rlt_pkg.sv @@
// Package: shared constants, codes and command/status types for the lock table.
package rlt_pkg;

  localparam int LockEntries = 16;
  localparam int ThreadCount = 16;
  localparam int ObjectBits  = 16;
  localparam int CountBits   = 16;

  localparam int KindW   = 2;
  localparam int ObjW    = 16;
  localparam int ThrW    = 4;
  localparam int StatusW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_TRY    = 2'd0,
    KIND_LOCK   = 2'd1,
    KIND_UNLOCK = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_HANDED   = 3'd2,
    ST_NULL     = 3'd3,
    ST_FULL     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic capture;  // register the request
    logic execute;  // evaluate and update tables, load result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic busy;
  } stat_t;

endpackage

@@ src/rlt_if.sv @@
// Interfaces: request and response valid/ready channels.
interface rlt_req_if;
  logic                       valid;
  logic                       ready;
  logic [rlt_pkg::KindW-1:0]  kind;
  logic [rlt_pkg::ObjW-1:0]   object_id;
  logic [rlt_pkg::ThrW-1:0]   thread_id;
  modport source (output valid, kind, object_id, thread_id, input ready);
  modport sink   (input valid, kind, object_id, thread_id, output ready);
endinterface

interface rlt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rlt_pkg::StatusW-1:0]  status;
  logic                         granted;
  logic                         woken_valid;
  logic [rlt_pkg::ThrW-1:0]     woken_thread;
  modport source (output valid, status, granted, woken_valid, woken_thread,
                  input ready);
  modport sink   (input valid, status, granted, woken_valid, woken_thread,
                  output ready);
endinterface

@@ src/rlt_ctrl.sv @@
// Controller: sequences capture, execute and result delivery.
module rlt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rlt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} state_t;
  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: if (out_ready) begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_exec_then_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid) else $error("execute without result");
`endif

endmodule

@@ src/rlt_dp.sv @@
// Datapath: lock table, wait slots, parallel matches and result registers.
module rlt_dp #(
  parameter int LOCK_ENTRIES = rlt_pkg::LockEntries,
  parameter int THREAD_COUNT = rlt_pkg::ThreadCount,
  parameter int OBJECT_BITS  = rlt_pkg::ObjectBits,
  parameter int COUNT_BITS   = rlt_pkg::CountBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rlt_pkg::cmd_t                cmd,
  input  logic [rlt_pkg::KindW-1:0]    kind,
  input  logic [rlt_pkg::ObjW-1:0]     object_id,
  input  logic [rlt_pkg::ThrW-1:0]     thread_id,
  output logic [rlt_pkg::StatusW-1:0]  status,
  output logic                         granted,
  output logic                         woken_valid,
  output logic [rlt_pkg::ThrW-1:0]     woken_thread
);

  localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int TW = $clog2(THREAD_COUNT);

  logic [rlt_pkg::KindW-1:0] req_kind;
  logic [OBJECT_BITS-1:0]    req_obj;
  logic [TW-1:0]             req_thr;

  logic [LOCK_ENTRIES-1:0]   entry_valid;
  logic [OBJECT_BITS-1:0]    entry_object [LOCK_ENTRIES];
  logic [TW-1:0]             entry_owner  [LOCK_ENTRIES];
  logic [COUNT_BITS-1:0]     entry_count  [LOCK_ENTRIES];
  logic [THREAD_COUNT-1:0]   wait_valid;
  logic [OBJECT_BITS-1:0]    wait_object  [THREAD_COUNT];

  logic [OBJECT_BITS-1:0] obj_in;
  logic [TW-1:0]          thr_mod;
  assign obj_in = OBJECT_BITS'(object_id);

  // Fold the thread id into range with a small constant table.
  always_comb begin
    thr_mod = '0;
    for (int v = 0; v < (1 << rlt_pkg::ThrW); v++) begin
      if (thread_id == rlt_pkg::ThrW'(v)) thr_mod = TW'(v % THREAD_COUNT);
    end
  end

  // Capture the request beat; thread id modulo the thread count.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= kind;
      req_obj  <= obj_in;
      req_thr  <= thr_mod;
    end
  end

  // Parallel matches with lowest-index priority.
  logic          hit, has_free, has_wait;
  logic [EW-1:0] hit_idx, free_idx;
  logic [TW-1:0] wait_idx;

  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = LOCK_ENTRIES-1; i >= 0; i--) begin
      if (entry_valid[i] && entry_object[i] == req_obj) begin
        hit = 1'b1; hit_idx = EW'(i);
      end
      if (!entry_valid[i]) begin
        has_free = 1'b1; free_idx = EW'(i);
      end
    end
    has_wait = 1'b0; wait_idx = '0;
    for (int t = THREAD_COUNT-1; t >= 0; t--) begin
      if (wait_valid[t] && wait_object[t] == req_obj) begin
        has_wait = 1'b1; wait_idx = TW'(t);
      end
    end
  end

  logic [COUNT_BITS-1:0] hit_count;
  logic [TW-1:0]         hit_owner;
  assign hit_count = entry_count[hit_idx];
  assign hit_owner = entry_owner[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      wait_valid   <= '0;
      status       <= rlt_pkg::ST_OK;
      granted      <= 1'b0;
      woken_valid  <= 1'b0;
      woken_thread <= '0;
    end else if (cmd.execute) begin
      status       <= rlt_pkg::ST_OK;
      granted      <= 1'b0;
      woken_valid  <= 1'b0;
      woken_thread <= '0;
      if (req_kind == rlt_pkg::KIND_NONE) begin
        // Unknown request: no change.
      end else if (req_obj == '0) begin
        status <= rlt_pkg::ST_NULL;
      end else if (req_kind == rlt_pkg::KIND_UNLOCK) begin
        if (hit) begin
          if (hit_count > COUNT_BITS'(1)) begin
            entry_count[hit_idx] <= hit_count - COUNT_BITS'(1);
          end else if (has_wait) begin
            wait_valid[wait_idx]  <= 1'b0;
            entry_owner[hit_idx]  <= wait_idx;
            entry_count[hit_idx]  <= COUNT_BITS'(1);
            status       <= rlt_pkg::ST_HANDED;
            woken_valid  <= 1'b1;
            woken_thread <= rlt_pkg::ThrW'(wait_idx);
          end else begin
            entry_valid[hit_idx] <= 1'b0;
          end
        end
      end else if (hit) begin
        if (hit_owner == req_thr) begin
          if (hit_count == '1) begin
            status <= rlt_pkg::ST_OVERFLOW;
          end else begin
            entry_count[hit_idx] <= hit_count + COUNT_BITS'(1);
            granted <= (req_kind == rlt_pkg::KIND_TRY);
          end
        end else if (req_kind == rlt_pkg::KIND_LOCK) begin
          wait_valid[req_thr]  <= 1'b1;
          wait_object[req_thr] <= req_obj;
          status <= rlt_pkg::ST_BLOCKED;
        end
      end else if (!has_free) begin
        status <= rlt_pkg::ST_FULL;
      end else begin
        entry_valid[free_idx]  <= 1'b1;
        entry_object[free_idx] <= req_obj;
        entry_owner[free_idx]  <= req_thr;
        entry_count[free_idx]  <= COUNT_BITS'(1);
        granted <= (req_kind == rlt_pkg::KIND_TRY);
      end
    end
  end

`ifndef ASSERT_OFF
  a_woken_handed: assert property (@(posedge clk) disable iff (rst)
    woken_valid |-> status == rlt_pkg::ST_HANDED) else $error("woken without handover");
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    granted |-> status == rlt_pkg::ST_OK) else $error("grant with error status");
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    status <= rlt_pkg::ST_OVERFLOW) else $error("illegal status code");
`endif

endmodule

@@ src/recursive_lock_table.sv @@
// Top level: recursive lock manager joining controller and datapath.
//
// Usage:
//   req (sink): one beat carries kind (try_lock, lock, unlock), object_id and
//   thread_id. rsp (source): one beat per request with status, granted,
//   woken_valid and woken_thread.
// Timing:
//   A request is taken in one cycle, evaluated the next (a parallel match of
//   the lock entries and of the per-thread wait slots, lowest index wins),
//   and its result is shown registered from the cycle after. Only one request
//   is in flight at a time: req is not ready again until the receiver has
//   taken the result.
// Reset:
//   rst (synchronous) clears all entry and wait valid bits and the handshake
//   state; the table is usable in the next cycle.
// Stall:
//   While rsp is stalled the result holds and req stays not ready.
module recursive_lock_table #(
  parameter int LOCK_ENTRIES = rlt_pkg::LockEntries,
  parameter int THREAD_COUNT = rlt_pkg::ThreadCount,
  parameter int OBJECT_BITS  = rlt_pkg::ObjectBits,
  parameter int COUNT_BITS   = rlt_pkg::CountBits
) (
  input logic    clk,
  input logic    rst,
  rlt_req_if.sink   req,
  rlt_rsp_if.source rsp
);

  rlt_pkg::cmd_t cmd;

  // Sequence the beat through capture and execute.
  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Hold the tables and compute the result.
  rlt_dp #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .THREAD_COUNT (THREAD_COUNT),
    .OBJECT_BITS  (OBJECT_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (req.kind),
    .object_id    (req.object_id),
    .thread_id    (req.thread_id),
    .status       (rsp.status),
    .granted      (rsp.granted),
    .woken_valid  (rsp.woken_valid),
    .woken_thread (rsp.woken_thread)
  );

endmodule
